// ===== rtl/core/ggpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared widths, constants, codes and the arctangent table of the go-to-goal
// pose controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;

    // pose offset to goal (Q6.10, one bit wider than the coordinates)
    localparam int OFS_W   = 17;
    // sum of squared offsets and its floor square root
    localparam int RAD_W   = 34;
    localparam int ROOT_W  = 17;
    // bearing and heading error in Q3.13
    localparam int ANG_W   = 18;
    // shared multiplier
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    // cordic angle accumulator, 2^30 per radian
    localparam int Z_W     = 34;

    localparam int ATAN_TBL_LEN = 24;
    localparam int ATAN_IDX_W   = 5;

    localparam logic signed [ANG_W-1:0] PI_Q13     = 18'sd25736;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [Z_W-1:0]   HALF_PI_Z  = 34'sd1686629713;

    // register indexes
    localparam logic [2:0] REG_GOAL_X       = 3'd0;
    localparam logic [2:0] REG_GOAL_Y       = 3'd1;
    localparam logic [2:0] REG_LINEAR_GAIN  = 3'd2;
    localparam logic [2:0] REG_ANGULAR_GAIN = 3'd3;
    localparam logic [2:0] REG_ARRIVE_TOL   = 3'd4;

    // run status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_REACHED  = 2'd1;
    localparam logic [1:0] ST_CANCELED = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_sts_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ANG_W-1:0] bearing;
    } cordic_sts_t;

    // atan(2^-i) scaled by 2^30
    function automatic logic signed [Z_W-1:0] atan_z(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/ggpc_pose_if.sv =====
// ----------------------------------------------------------------------------
// ggpc_pose_if
// Pose channel: one item per control tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ggpc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
    logic               cancel_request;

    modport source (
        output valid,
        output pose_x,
        output pose_y,
        output pose_heading,
        output cancel_request,
        input  ready
    );

    modport sink (
        input  valid,
        input  pose_x,
        input  pose_y,
        input  pose_heading,
        input  cancel_request,
        output ready
    );
endinterface

// ===== rtl/core/ggpc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ggpc_cmd_if
// Command channel: one result item per pose item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ggpc_cmd_if;
    logic               valid;
    logic               ready;
    logic        [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic        [15:0] goal_distance;
    logic        [1:0]  run_status;

    modport source (
        output valid,
        output linear_cmd,
        output angular_cmd,
        output goal_distance,
        output run_status,
        input  ready
    );

    modport sink (
        input  valid,
        input  linear_cmd,
        input  angular_cmd,
        input  goal_distance,
        input  run_status,
        output ready
    );
endinterface

// ===== rtl/core/go_to_goal_pose_controller.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller
// Proportional go-to-goal law for a unicycle: distance and cordic bearing to
// the goal, wrapped heading error, saturating speed and turn rate commands.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  pose      in         pose.valid/ready     pose_x, pose_y, pose_heading,
//                                            cancel_request
//  cmd       out        cmd.valid/ready      linear_cmd, angular_cmd,
//                                            goal_distance, run_status
//  apb       in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
//  a running item steps through sqx, sqy, sum and run, where the square root
//  and cordic work alongside, then lin, ang and fin unless the goal is reached,
//  and done; it makes up to four passes through the shared multiplier. idle and
//  cancel items go from accept straight to done. one item is in work at a time;
//  the next is taken while the previous result waits.
//  reset loads the register reset values and arms the goal; no memory sweep.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller
    import ggpc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    ggpc_pose_if.sink   pose,
    ggpc_cmd_if.source  cmd,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_RUN,
        S_LIN,
        S_ANG,
        S_FIN,
        S_DONE
    } state_t;

    state_t state_reg;

    logic signed [15:0] goal_x_reg;
    logic signed [15:0] goal_y_reg;
    logic [15:0]        linear_gain_reg;
    logic [15:0]        angular_gain_reg;
    logic [15:0]        arrive_tol_reg;
    logic               goal_active_reg;
    logic               out_valid_reg;

    logic signed [OFS_W-1:0]  dx_reg;
    logic signed [OFS_W-1:0]  dy_reg;
    logic signed [15:0]       heading_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic [RAD_W-1:0]         acc_reg;
    logic [ROOT_W-1:0]        dist_reg;
    logic signed [ANG_W-1:0]  err_reg;
    logic [15:0]              res_lin_reg;
    logic signed [15:0]       res_ang_reg;
    logic [15:0]              res_dist_reg;
    logic [1:0]               res_stat_reg;
    logic [15:0]              out_lin_reg;
    logic signed [15:0]       out_ang_reg;
    logic [15:0]              out_dist_reg;
    logic [1:0]               out_stat_reg;

    logic                     pose_acc;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;
    logic                     units_done;
    logic                     reached;
    logic                     out_load;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic [RAD_W-1:0]         radicand;
    logic signed [ANG_W-1:0]  err_raw;
    logic signed [ANG_W-1:0]  err_wrap;
    logic [15:0]              dist_sat;
    logic signed [PROD_W-1:0] lin_rnd;
    logic signed [PROD_W-1:0] ang_rnd;
    logic signed [PROD_W-1:0] ang_sh;
    logic [15:0]              lin_sat;
    logic signed [15:0]       ang_sat;
    logic                     sqrt_start;

    sqrt_sts_t   sqrt_sts;
    cordic_sts_t cordic_sts;

    // ---------------- handshakes ----------------
    assign pose.ready = (state_reg == S_IDLE);
    assign pose_acc   = pose.valid && pose.ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || cmd.ready);

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_GOAL_X:       prdata = {{16{goal_x_reg[15]}}, goal_x_reg};
            REG_GOAL_Y:       prdata = {{16{goal_y_reg[15]}}, goal_y_reg};
            REG_LINEAR_GAIN:  prdata = {16'b0, linear_gain_reg};
            REG_ANGULAR_GAIN: prdata = {16'b0, angular_gain_reg};
            REG_ARRIVE_TOL:   prdata = {16'b0, arrive_tol_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- shared multiplier operands ----------------
    always_comb
    begin
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_SQY:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_LIN:
            begin
                mul_a = {2'b00, linear_gain_reg};
                mul_b = {1'b0, dist_reg};
            end
            S_ANG:
            begin
                mul_a = {2'b00, angular_gain_reg};
                mul_b = err_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- arithmetic units ----------------
    assign sqrt_start = (state_reg == S_SUM);
    assign radicand   = acc_reg + RAD_W'(mul_reg);

    ggpc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .sts      (sqrt_sts)
    );

    ggpc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .sts   (cordic_sts)
    );

    assign units_done = !sqrt_sts.busy && !cordic_sts.busy;
    assign reached    = (sqrt_sts.root < {1'b0, arrive_tol_reg});
    assign dist_sat   = sqrt_sts.root[ROOT_W-1] ? 16'hFFFF : sqrt_sts.root[15:0];

    // heading error wrapped by one turn
    assign err_raw = cordic_sts.bearing - ANG_W'(heading_reg);
    always_comb
    begin
        priority if (err_raw > PI_Q13)
        begin
            err_wrap = err_raw - TWO_PI_Q13;
        end
        else if (err_raw < -PI_Q13)
        begin
            err_wrap = err_raw + TWO_PI_Q13;
        end
        else
        begin
            err_wrap = err_raw;
        end
    end

    // rounding and saturation of the gain products
    assign lin_rnd = mul_reg + PROD_W'(2048);
    assign lin_sat = (lin_rnd[PROD_W-1:28] != '0) ? 16'hFFFF : lin_rnd[27:12];

    assign ang_rnd = mul_reg + PROD_W'(16384);
    assign ang_sh  = ang_rnd >>> 15;
    always_comb
    begin
        priority if (ang_sh > PROD_W'(32767))
        begin
            ang_sat = 16'sh7FFF;
        end
        else if (ang_sh < -PROD_W'(32768))
        begin
            ang_sat = -16'sh8000;
        end
        else
        begin
            ang_sat = ang_sh[15:0];
        end
    end

    // ---------------- sequencer and control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            linear_gain_reg  <= 16'd4096;
            angular_gain_reg <= 16'd16384;
            arrive_tol_reg   <= 16'd102;
            goal_active_reg  <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_GOAL_X:       goal_x_reg       <= pwdata[15:0];
                    REG_GOAL_Y:       goal_y_reg       <= pwdata[15:0];
                    REG_LINEAR_GAIN:  linear_gain_reg  <= pwdata[15:0];
                    REG_ANGULAR_GAIN: angular_gain_reg <= pwdata[15:0];
                    REG_ARRIVE_TOL:   arrive_tol_reg   <= pwdata[15:0];
                    default:          ;
                endcase
                if (cfg_idx <= REG_ARRIVE_TOL)
                begin
                    goal_active_reg <= 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pose_acc)
                    begin
                        priority if (!goal_active_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (pose.cancel_request)
                        begin
                            goal_active_reg <= 1'b0;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SQX;
                        end
                    end
                end
                S_SQX: state_reg <= S_SQY;
                S_SQY: state_reg <= S_SUM;
                S_SUM: state_reg <= S_RUN;
                S_RUN:
                begin
                    if (units_done)
                    begin
                        if (reached)
                        begin
                            goal_active_reg <= 1'b0;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LIN;
                        end
                    end
                end
                S_LIN: state_reg <= S_ANG;
                S_ANG: state_reg <= S_FIN;
                S_FIN: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;

        if (pose_acc)
        begin
            dx_reg       <= OFS_W'(goal_x_reg) - OFS_W'(pose.pose_x);
            dy_reg       <= OFS_W'(goal_y_reg) - OFS_W'(pose.pose_y);
            heading_reg  <= pose.pose_heading;
            res_lin_reg  <= '0;
            res_ang_reg  <= '0;
            res_dist_reg <= '0;
            if (!goal_active_reg)
            begin
                res_stat_reg <= ST_IDLE;
            end
            else
            begin
                res_stat_reg <= ST_CANCELED;
            end
        end

        if (state_reg == S_SQY)
        begin
            acc_reg <= RAD_W'(mul_reg);
        end

        if ((state_reg == S_RUN) && units_done)
        begin
            dist_reg     <= sqrt_sts.root;
            err_reg      <= err_wrap;
            res_dist_reg <= dist_sat;
            res_stat_reg <= reached ? ST_REACHED : ST_RUNNING;
        end

        if (state_reg == S_ANG)
        begin
            res_lin_reg <= lin_sat;
        end

        if (state_reg == S_FIN)
        begin
            res_ang_reg <= ang_sat;
        end

        if (out_load)
        begin
            out_lin_reg  <= res_lin_reg;
            out_ang_reg  <= res_ang_reg;
            out_dist_reg <= res_dist_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.linear_cmd    = out_lin_reg;
    assign cmd.angular_cmd   = out_ang_reg;
    assign cmd.goal_distance = out_dist_reg;
    assign cmd.run_status    = out_stat_reg;

`ifndef SYNTHESIS
    // no pose is taken while the root or bearing is still being worked out
    assert property (@(posedge clk) disable iff (!rst_n)
        pose.ready |-> (!sqrt_sts.busy && !cordic_sts.busy))
        else $error("pose taken while arithmetic units busy");

    // an idle result carries no motion and no distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.run_status == ST_IDLE)) |->
        ((cmd.linear_cmd == '0) && (cmd.angular_cmd == '0) && (cmd.goal_distance == '0)))
        else $error("idle result with nonzero fields");

    // a fresh reached or canceled result leaves the goal disarmed
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(cmd.valid) &&
         ((cmd.run_status == ST_REACHED) || (cmd.run_status == ST_CANCELED)))
        |-> !goal_active_reg)
        else $error("goal still armed after stop result");

    // a reached result stops the robot
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.run_status == ST_REACHED)) |->
        ((cmd.linear_cmd == '0) && (cmd.angular_cmd == '0)))
        else $error("reached result with nonzero commands");
`endif

endmodule

// ===== rtl/core/ggpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ggpc_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ggpc_sqrt
    import ggpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    output sqrt_sts_t        sts
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.root = root_reg;

endmodule

// ===== rtl/core/ggpc_cordic.sv =====
// ----------------------------------------------------------------------------
// ggpc_cordic
// Iterative cordic in vectoring mode: bearing of the offset in Q3.13.
// ----------------------------------------------------------------------------
module ggpc_cordic
    import ggpc_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [OFS_W-1:0] dx,
    input  logic signed [OFS_W-1:0] dy,
    output cordic_sts_t             sts
);

    localparam int XY_W  = 28;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   zero_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  step_z;
    logic signed [Z_W-1:0]  z_rnd;

    // offsets scaled by 256
    assign x0 = {{(XY_W-OFS_W-8){dx[OFS_W-1]}}, dx, 8'b0};
    assign y0 = {{(XY_W-OFS_W-8){dy[OFS_W-1]}}, dy, 8'b0};

    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign step_z = atan_z(ATAN_IDX_W'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (dx == '0) && (dy == '0);
            // left half plane: rotate by a quarter turn first
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_reg <= y0;
                    y_reg <= -x0;
                    z_reg <= HALF_PI_Z;
                end
                else
                begin
                    x_reg <= -y0;
                    y_reg <= x0;
                    z_reg <= -HALF_PI_Z;
                end
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_z;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_z;
            end
        end
    end

    // round half up from 2^30 per radian to Q3.13
    assign z_rnd    = z_reg + 34'sd65536;
    assign sts.busy = busy_reg;
    assign sts.bearing = zero_reg ? '0 : {z_rnd[Z_W-1], z_rnd[Z_W-1:17]};

endmodule
